@@ rtl/scfb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scfb_pkg
// Types and constants shared by the servo command frame builder.
// ----------------------------------------------------------------------------
package scfb_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_BOARD_NUMBER = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FREEZE_EN    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PWM_EN       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PWM_REPEAT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_PWM_SWEEP    = 3'd4;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_FRAME = 2'd1;
    localparam logic [1:0] FUNC_PWM   = 2'd2;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_OVERWRITE = 3'd1;
    localparam logic [2:0] STATUS_BAD_SERVO = 3'd2;
    localparam logic [2:0] STATUS_BAD_POS   = 3'd3;
    localparam logic [2:0] STATUS_NO_PWM    = 3'd4;

    localparam logic [7:0] CMD_SPECIAL  = 8'd159;
    localparam logic [7:0] CMD_FREEZE   = 8'd15;
    localparam logic [7:0] CMD_RESUME   = 8'd0;
    localparam logic [7:0] CMD_PWM      = 8'd158;
    localparam logic [6:0] MAX_POSITION = 7'd97;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] servo_number;
        logic [6:0] position_value;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic [2:0] status;
    } rsp_item_t;

    typedef struct packed {
        logic [2:0] board_number;
        logic       freeze_enable;
        logic       pwm_enable;
        logic [2:0] pwm_repeat_index;
        logic [3:0] pwm_sweep;
    } cfg_t;

endpackage
`default_nettype wire

@@ rtl/servo_command_frame_builder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// servo_command_frame_builder
// Servo position table and serial command frame builder.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (cmd) is taken on a clock edge with start high
//   and busy low. Write items store a servo position; frame items emit the
//   stored table as address/position byte pairs, optionally wrapped in
//   freeze/resume pairs; PWM items emit the PWM command pair.
//   Result channel: each result sits on rsp for one cycle with rsp_strobe
//   high. The last result of an item carries last. Results cannot be held.
//   Config port: cfg_wr with cfg_addr/cfg_data writes a register.
//   Write items, an empty frame without freeze and a disabled PWM item give
//   their single result in the cycle after acceptance; busy stays low.
//   A frame is busy in a SCAN and a POS state per stored servo, a SCAN
//   state per empty slot below the highest stored one, and FRZ_HI/FRZ_LO
//   and RES_HI/RES_LO with freeze. It gives at most 2*NUM_SERVOS+4 bytes
//   (28 at 12). A PWM item is busy in PWM_HI and PWM_LO.
//   The scan sequencer steps the table one entry at a time, pausing in POS
//   on each stored entry; busy stays high until the final byte is formed.
//   Reset clears all valid flags and config registers to their defaults.
// ----------------------------------------------------------------------------
module servo_command_frame_builder #(
    parameter int NUM_SERVOS = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire scfb_pkg::cmd_item_t             cmd,
    input  wire logic                            cfg_wr,
    input  wire logic [scfb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [scfb_pkg::CFG_DATA_W-1:0] cfg_data,
    output scfb_pkg::rsp_item_t                  rsp,
    output logic                                 rsp_strobe
);

    localparam int IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

    scfb_pkg::cfg_t      cfg_reg;
    scfb_pkg::cfg_t      cfg_next;
    scfb_pkg::rsp_item_t rsp_reg;
    logic                strobe_reg;

    logic                  tbl_wr;
    logic [IDX_W-1:0]      tbl_idx;
    logic [IDX_W-1:0]      scan_idx;
    logic [6:0]            rd_pos;
    logic [NUM_SERVOS-1:0] valid_vec;
    logic                  any_valid;
    logic                  more_above;
    logic                  emit;
    scfb_pkg::rsp_item_t   res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_addr)
                scfb_pkg::REG_BOARD_NUMBER: cfg_next.board_number     = cfg_data[2:0];
                scfb_pkg::REG_FREEZE_EN:    cfg_next.freeze_enable    = cfg_data[0];
                scfb_pkg::REG_PWM_EN:       cfg_next.pwm_enable       = cfg_data[0];
                scfb_pkg::REG_PWM_REPEAT:   cfg_next.pwm_repeat_index = cfg_data[2:0];
                scfb_pkg::REG_PWM_SWEEP:    cfg_next.pwm_sweep        = cfg_data[3:0];
                default:                    cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.board_number     <= 3'd1;
            cfg_reg.freeze_enable    <= 1'b0;
            cfg_reg.pwm_enable       <= 1'b0;
            cfg_reg.pwm_repeat_index <= 3'd0;
            cfg_reg.pwm_sweep        <= 4'd0;
            strobe_reg               <= 1'b0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            strobe_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_reg <= res;
        end
    end

    scfb_table #(
        .NUM_SERVOS (NUM_SERVOS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (tbl_wr),
        .wr_idx     (tbl_idx),
        .wr_pos     (cmd.position_value),
        .rd_idx     (scan_idx),
        .rd_pos     (rd_pos),
        .valid_vec  (valid_vec),
        .any_valid  (any_valid),
        .more_above (more_above)
    );

    scfb_seq #(
        .NUM_SERVOS (NUM_SERVOS),
        .IDX_W      (IDX_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .valid_vec  (valid_vec),
        .any_valid  (any_valid),
        .more_above (more_above),
        .rd_pos     (rd_pos),
        .busy       (busy),
        .tbl_wr     (tbl_wr),
        .tbl_idx    (tbl_idx),
        .scan_idx   (scan_idx),
        .emit       (emit),
        .res        (res)
    );

    assign rsp        = rsp_reg;
    assign rsp_strobe = strobe_reg;

    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_strobe && rsp.byte_valid |-> rsp.status == scfb_pkg::STATUS_OK)
        else $error("emitted byte with non-ok status");

    a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_strobe && !rsp.byte_valid |-> rsp.last)
        else $error("status-only result not marked last");

    a_write_resp: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.func == scfb_pkg::FUNC_WRITE |=> rsp_strobe && rsp.last)
        else $error("write item gave no result");

endmodule
`default_nettype wire

@@ rtl/scfb_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scfb_table
// Servo position store with per-entry valid flags and a look-ahead for
// further valid entries above the scan index.
// ----------------------------------------------------------------------------
module scfb_table #(
    parameter int NUM_SERVOS = 12,
    parameter int IDX_W      = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire logic [IDX_W-1:0]      wr_idx,
    input  wire logic [6:0]            wr_pos,
    input  wire logic [IDX_W-1:0]      rd_idx,
    output logic      [6:0]            rd_pos,
    output logic      [NUM_SERVOS-1:0] valid_vec,
    output logic                       any_valid,
    output logic                       more_above
);

    logic [6:0]            pos_reg [NUM_SERVOS];
    logic [6:0]            rd_pos_reg;
    logic [NUM_SERVOS-1:0] valid_reg;
    logic [NUM_SERVOS-1:0] valid_next;

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // read data is taken while the scan sits on an entry, ready for the next cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_reg[wr_idx] <= wr_pos;
        end
        rd_pos_reg <= pos_reg[rd_idx];
    end

    always_comb
    begin
        logic [NUM_SERVOS-1:0] above;
        above = '0;
        for (int i = 0; i < NUM_SERVOS; i++)
        begin
            above[i] = valid_reg[i] && (IDX_W'(i) > rd_idx);
        end
        more_above = |above;
    end

    assign rd_pos    = rd_pos_reg;
    assign valid_vec = valid_reg;
    assign any_valid = |valid_reg;

endmodule
`default_nettype wire

@@ rtl/scfb_seq.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scfb_seq
// Command sequencer: decodes an item, steps the servo scan index one entry
// at a time and forms at most one result byte per cycle.
// ----------------------------------------------------------------------------
module scfb_seq #(
    parameter int NUM_SERVOS = 12,
    parameter int IDX_W      = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire scfb_pkg::cmd_item_t     cmd,
    input  wire scfb_pkg::cfg_t          cfg,
    input  wire logic [NUM_SERVOS-1:0]   valid_vec,
    input  wire logic                    any_valid,
    input  wire logic                    more_above,
    input  wire logic [6:0]              rd_pos,
    output logic                         busy,
    output logic                         tbl_wr,
    output logic      [IDX_W-1:0]        tbl_idx,
    output logic      [IDX_W-1:0]        scan_idx,
    output logic                         emit,
    output scfb_pkg::rsp_item_t          res
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_FRZ_HI = 9'b000000010,
        ST_FRZ_LO = 9'b000000100,
        ST_SCAN   = 9'b000001000,
        ST_POS    = 9'b000010000,
        ST_RES_HI = 9'b000100000,
        ST_RES_LO = 9'b001000000,
        ST_PWM_HI = 9'b010000000,
        ST_PWM_LO = 9'b100000000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SERVOS - 1);

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             servo_ok;
    logic             pos_ok;

    assign servo_ok = (cmd.servo_number != 4'd0)
                   && ({1'b0, cmd.servo_number} <= 5'(NUM_SERVOS));
    assign pos_ok   = (cmd.position_value != 7'd0)
                   && (cmd.position_value <= scfb_pkg::MAX_POSITION);
    assign tbl_idx  = IDX_W'(cmd.servo_number - 4'd1);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        tbl_wr         = 1'b0;
        emit           = 1'b0;
        res.out_byte   = 8'd0;
        res.byte_valid = 1'b1;
        res.last       = 1'b0;
        res.status     = scfb_pkg::STATUS_OK;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    case (cmd.func)
                        scfb_pkg::FUNC_WRITE:
                        begin
                            emit           = 1'b1;
                            res.byte_valid = 1'b0;
                            res.last       = 1'b1;
                            if (!servo_ok)
                            begin
                                res.status = scfb_pkg::STATUS_BAD_SERVO;
                            end
                            else if (!pos_ok)
                            begin
                                res.status = scfb_pkg::STATUS_BAD_POS;
                            end
                            else
                            begin
                                tbl_wr     = 1'b1;
                                res.status = valid_vec[tbl_idx]
                                           ? scfb_pkg::STATUS_OVERWRITE
                                           : scfb_pkg::STATUS_OK;
                            end
                        end
                        scfb_pkg::FUNC_FRAME:
                        begin
                            if (cfg.freeze_enable)
                            begin
                                state_next = ST_FRZ_HI;
                            end
                            else if (any_valid)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                emit           = 1'b1;
                                res.byte_valid = 1'b0;
                                res.last       = 1'b1;
                            end
                        end
                        scfb_pkg::FUNC_PWM:
                        begin
                            if (cfg.pwm_enable)
                            begin
                                state_next = ST_PWM_HI;
                            end
                            else
                            begin
                                emit           = 1'b1;
                                res.byte_valid = 1'b0;
                                res.last       = 1'b1;
                                res.status     = scfb_pkg::STATUS_NO_PWM;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FRZ_HI:
            begin
                emit         = 1'b1;
                res.out_byte = scfb_pkg::CMD_SPECIAL;
                state_next   = ST_FRZ_LO;
            end
            ST_FRZ_LO:
            begin
                emit         = 1'b1;
                res.out_byte = scfb_pkg::CMD_FREEZE;
                state_next   = any_valid ? ST_SCAN : ST_RES_HI;
            end
            ST_SCAN:
            begin
                if (valid_vec[idx_reg])
                begin
                    emit         = 1'b1;
                    res.out_byte = {1'b1, cfg.board_number, 4'(idx_reg)};
                    state_next   = ST_POS;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = cfg.freeze_enable ? ST_RES_HI : ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_POS:
            begin
                emit         = 1'b1;
                res.out_byte = {1'b0, rd_pos};
                res.last     = !more_above && !cfg.freeze_enable;
                if (more_above)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = cfg.freeze_enable ? ST_RES_HI : ST_IDLE;
                end
            end
            ST_RES_HI:
            begin
                emit         = 1'b1;
                res.out_byte = scfb_pkg::CMD_SPECIAL;
                state_next   = ST_RES_LO;
            end
            ST_RES_LO:
            begin
                emit         = 1'b1;
                res.out_byte = scfb_pkg::CMD_RESUME;
                res.last     = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_PWM_HI:
            begin
                emit         = 1'b1;
                res.out_byte = scfb_pkg::CMD_PWM;
                state_next   = ST_PWM_LO;
            end
            ST_PWM_LO:
            begin
                emit         = 1'b1;
                res.out_byte = {1'b0, cfg.pwm_repeat_index, cfg.pwm_sweep};
                res.last     = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy     = (state_reg != ST_IDLE);
    assign scan_idx = idx_reg;

endmodule
`default_nettype wire
